[design/jesc_pkg.sv]
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types and codes for the Julia escape-time iteration store.
// ----------------------------------------------------------------------------
package jesc_pkg;

  // Number of fraction bits of the Q6.26 values.
  localparam int FRAC_BITS = 26;

  // Width of the configuration byte address.
  localparam int ADDR_W = 4;

  // Item commands.
  localparam logic CMD_ITERATE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes (byte address bits [3:2]).
  typedef enum logic [1:0] {
    REG_C_RE      = 2'd0,
    REG_C_IM      = 2'd1,
    REG_POWER     = 2'd2,
    REG_MAX_DEPTH = 2'd3
  } reg_idx_t;

  // Configuration as seen by the iteration engine.
  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [2:0]         power;
    logic [15:0]        max_depth;
  } cfg_t;

endpackage

[design/jesc_queue.sv]
// ----------------------------------------------------------------------------
// jesc_queue
// Two-entry queue between the item front end and the iteration engine.
// ----------------------------------------------------------------------------
module jesc_queue #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rp_r];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

[design/jesc_front.sv]
// ----------------------------------------------------------------------------
// jesc_front
// Accepts items, classifies them and forms the linear pixel index.
// ----------------------------------------------------------------------------
module jesc_front #(
  parameter int GRID_SIDE = 128,
  parameter int AW        = 14
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [6:0]  in_x,
  input  logic [6:0]  in_y,
  input  logic        q_full,
  input  logic        busy,
  output logic        push,
  output logic [AW:0] push_data
);

  logic [6:0]    xm;
  logic [6:0]    ym;
  logic [AW-1:0] idx;

  // Hold off transfers while the grid is initialized or the queue is full.
  assign in_stall = busy | q_full;
  assign push     = in_valid & ~in_stall;

  // Fold the coordinates into the grid, then form row * side + column.
  always_comb begin
    xm = in_x;
    ym = in_y;
    for (int i = 0; i < 8; i++) begin
      if (int'(xm) >= GRID_SIDE) begin
        xm = xm - 7'(GRID_SIDE);
      end
      if (int'(ym) >= GRID_SIDE) begin
        ym = ym - 7'(GRID_SIDE);
      end
    end
    idx = AW'(ym) * AW'(GRID_SIDE) + AW'(xm);
  end

  assign push_data = {in_cmd == jesc_pkg::CMD_RESTART, idx};

endmodule

[design/jesc_back.sv]
// ----------------------------------------------------------------------------
// jesc_back
// Iteration engine: pixel store, grid sweep, shared multiplier and divider.
// ----------------------------------------------------------------------------
module jesc_back #(
  parameter int GRID_SIDE  = 128,
  parameter int COUNT_BITS = 16,
  parameter int AW         = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  jesc_pkg::cfg_t   cfg,
  input  logic             q_empty,
  input  logic [AW:0]      q_data,
  output logic             q_pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_count,
  output logic [7:0]       out_green,
  output logic             out_skipped
);

  localparam int HALF  = GRID_SIDE / 2;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int XW    = $clog2(GRID_SIDE);
  localparam int TW    = $clog2(HALF + 1);
  localparam int KMAP  = 5 * (2 ** 25);
  localparam int KQ    = KMAP / HALF;
  localparam int KR    = KMAP % HALF;
  localparam int NW    = COUNT_BITS + 8;
  localparam int MW    = COUNT_BITS + 64;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [65:0] ESCAPE_LIM = 66'sd18014398509481984;

  typedef enum logic [3:0] {
    ST_TBL, ST_SWEEP, ST_DRAIN, ST_IDLE, ST_RD, ST_LD, ST_MUL, ST_ACC,
    ST_SHIFT, ST_ADDC, ST_WB, ST_DIV
  } state_t;

  typedef enum logic {MODE_MAG, MODE_CMUL} mode_t;

  state_t state_r;
  mode_t  mode_r;

  // Pixel store and coordinate table.
  logic [MW-1:0]      mem_r [CELLS];
  logic [MW-1:0]      mem_q_r;
  logic signed [31:0] ftbl_r [HALF + 1];
  logic signed [31:0] fx_r;
  logic signed [31:0] fy_r;

  // Table fill and sweep.
  logic [TW-1:0]   td_r;
  logic [31:0]     tq_r;
  logic [XW-1:0]   tr_r;
  logic [XW:0]     tr_sum;
  logic [XW-1:0]   sx_r;
  logic [XW-1:0]   sy_r;
  logic [AW-1:0]   sk_r;
  logic [XW-1:0]   dx;
  logic [XW-1:0]   dy;
  logic            negx_r;
  logic            negy_r;
  logic [AW-1:0]   sw_wa_r;
  logic            sw_we_r;
  logic            busy_r;

  // Iteration datapath.
  logic [AW-1:0]           k_r;
  logic [COUNT_BITS-1:0]   n_r;
  logic [COUNT_BITS-1:0]   max_r;
  logic [COUNT_BITS-1:0]   max_new;
  logic signed [31:0]      zr_r;
  logic signed [31:0]      zi_r;
  logic signed [31:0]      wr_r;
  logic signed [31:0]      wi_r;
  logic signed [31:0]      opa;
  logic signed [31:0]      opb;
  logic signed [63:0]      prod_r;
  logic signed [65:0]      prod_x;
  logic signed [65:0]      acc_re_r;
  logic signed [65:0]      acc_im_r;
  logic [1:0]              step_r;
  logic [1:0]              iter_r;
  logic [1:0]              iters;
  logic                    can_pop;
  logic                    skip_hit;

  // Divider.
  logic [NW-1:0] num_r;
  logic [NW-1:0] dsh_r;
  logic [7:0]    quo_r;
  logic [2:0]    dcnt_r;
  logic          qbit;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [15:0]       out_count_r;
  logic [7:0]        out_green_r;
  logic              out_skipped_r;

  // Memory write port.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_count   = out_count_r;
  assign out_green   = out_green_r;
  assign out_skipped = out_skipped_r;

  // Incremental quotient and remainder for the coordinate table.
  assign tr_sum = {1'b0, tr_r} + (XW + 1)'(KR);

  // Distance of the sweep position from the grid center.
  assign dx = (int'(sx_r) >= HALF) ? sx_r - XW'(HALF) : XW'(HALF) - sx_r;
  assign dy = (int'(sy_r) >= HALF) ? sy_r - XW'(HALF) : XW'(HALF) - sy_r;

  // Exponent 0 behaves as 1 and anything above 4 as 4.
  always_comb begin
    if (cfg.power == 3'd0) begin
      iters = 2'd0;
    end else if (cfg.power > 3'd4) begin
      iters = 2'd3;
    end else begin
      iters = 2'(cfg.power - 3'd1);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    opa = zr_r;
    opb = zr_r;
    if (mode_r == MODE_MAG) begin
      if (step_r[0]) begin
        opa = zi_r;
        opb = zi_r;
      end
    end else begin
      case (step_r)
        2'd0: begin
          opa = wr_r;
          opb = zr_r;
        end
        2'd1: begin
          opa = wi_r;
          opb = zi_r;
        end
        2'd2: begin
          opa = wr_r;
          opb = zi_r;
        end
        default: begin
          opa = wi_r;
          opb = zr_r;
        end
      endcase
    end
  end

  assign prod_x   = 66'(prod_r);
  assign max_new  = (n_r > max_r) ? n_r : max_r;
  assign qbit     = (num_r >= dsh_r);
  assign can_pop  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop    = (state_r == ST_IDLE) && can_pop;
  assign skip_hit = (32'(max_r) >= 32'(cfg.max_depth));

  // A result is loaded by a restart, a skipped item or the last divide step,
  // and is held while the receiver stalls.
  assign out_valid_nxt = (q_pop && (q_data[AW] || skip_hit))
                       || (state_r == ST_DIV && dcnt_r == 3'd7)
                       || (out_valid_r && out_stall);

  // Write port: sweep writes first, then the engine write-back.
  assign mem_we = sw_we_r | (state_r == ST_WB);
  assign mem_wa = sw_we_r ? sw_wa_r : k_r;
  assign mem_wd = sw_we_r ? {{COUNT_BITS{1'b0}}, (negx_r ? -fx_r : fx_r),
                             (negy_r ? -fy_r : fy_r)}
                          : {n_r, zr_r, zi_r};

  // Pixel store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem_r[k_r];
  end

  // Coordinate table with two registered reads.
  always_ff @(posedge clk) begin
    if (state_r == ST_TBL) begin
      ftbl_r[td_r] <= tq_r;
    end
    fx_r <= ftbl_r[TW'(dx)];
    fy_r <= ftbl_r[TW'(dy)];
  end

  // Sequencer with its datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TBL;
      mode_r      <= MODE_MAG;
      busy_r      <= 1'b1;
      sw_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= COUNT_BITS'(1);
      td_r        <= '0;
      tq_r        <= '0;
      tr_r        <= '0;
      step_r      <= '0;
      iter_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sw_we_r     <= (state_r == ST_SWEEP);
      unique case (state_r)
        ST_TBL: begin
          td_r <= td_r + TW'(1);
          if (tr_sum >= (XW + 1)'(HALF)) begin
            tr_r <= XW'(tr_sum - (XW + 1)'(HALF));
            tq_r <= tq_r + 32'(KQ) + 32'd1;
          end else begin
            tr_r <= XW'(tr_sum);
            tq_r <= tq_r + 32'(KQ);
          end
          if (int'(td_r) == HALF) begin
            sx_r    <= '0;
            sy_r    <= '0;
            sk_r    <= '0;
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          negx_r  <= (int'(sx_r) < HALF);
          negy_r  <= (int'(sy_r) < HALF);
          sw_wa_r <= sk_r;
          sk_r    <= sk_r + AW'(1);
          if (sx_r == XW'(GRID_SIDE - 1)) begin
            sx_r <= '0;
            sy_r <= sy_r + XW'(1);
            if (sy_r == XW'(GRID_SIDE - 1)) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            sx_r <= sx_r + XW'(1);
          end
        end
        ST_DRAIN: begin
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (can_pop) begin
            if (q_data[AW]) begin
              max_r         <= COUNT_BITS'(1);
              out_count_r   <= '0;
              out_green_r   <= '0;
              out_skipped_r <= 1'b0;
              sx_r          <= '0;
              sy_r          <= '0;
              sk_r          <= '0;
              state_r       <= ST_SWEEP;
            end else if (skip_hit) begin
              out_count_r   <= '0;
              out_green_r   <= '0;
              out_skipped_r <= 1'b1;
            end else begin
              k_r     <= q_data[AW-1:0];
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_LD;
        end
        ST_LD: begin
          n_r     <= mem_q_r[MW-1 -: COUNT_BITS];
          zr_r    <= mem_q_r[63:32];
          zi_r    <= mem_q_r[31:0];
          wr_r    <= mem_q_r[63:32];
          wi_r    <= mem_q_r[31:0];
          mode_r  <= MODE_MAG;
          step_r  <= 2'd0;
          iter_r  <= iters;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= opa * opb;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          case (step_r)
            2'd0:    acc_re_r <= prod_x;
            2'd1:    acc_re_r <= (mode_r == MODE_MAG) ? acc_re_r + prod_x
                                                      : acc_re_r - prod_x;
            2'd2:    acc_im_r <= prod_x;
            default: acc_im_r <= acc_im_r + prod_x;
          endcase
          if ((mode_r == MODE_MAG && step_r == 2'd1) || step_r == 2'd3) begin
            state_r <= ST_SHIFT;
          end else begin
            step_r  <= step_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_SHIFT: begin
          step_r <= 2'd0;
          if (mode_r == MODE_MAG) begin
            // Outside the radius-two circle the pixel keeps its state.
            if (acc_re_r >= ESCAPE_LIM) begin
              state_r <= ST_WB;
            end else if (iter_r == 2'd0) begin
              state_r <= ST_ADDC;
            end else begin
              mode_r  <= MODE_CMUL;
              state_r <= ST_MUL;
            end
          end else begin
            wr_r   <= sat32(acc_re_r >>> jesc_pkg::FRAC_BITS);
            wi_r   <= sat32(acc_im_r >>> jesc_pkg::FRAC_BITS);
            iter_r <= iter_r - 2'd1;
            if (iter_r == 2'd1) begin
              state_r <= ST_ADDC;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_ADDC: begin
          zr_r <= sat32(66'(wr_r) + 66'(cfg.c_re));
          zi_r <= sat32(66'(wi_r) + 66'(cfg.c_im));
          if (n_r != COUNT_MAX) begin
            n_r <= n_r + COUNT_BITS'(1);
          end
          state_r <= ST_WB;
        end
        ST_WB: begin
          max_r   <= max_new;
          num_r   <= {n_r, 8'd0} - NW'(n_r);
          dsh_r   <= {1'b0, max_new, 7'd0};
          quo_r   <= '0;
          dcnt_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (qbit) begin
            num_r <= num_r - dsh_r;
          end
          quo_r  <= {quo_r[6:0], qbit};
          dsh_r  <= dsh_r >> 1;
          dcnt_r <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd7) begin
            out_count_r   <= 16'(n_r);
            out_green_r   <= {quo_r[6:0], qbit};
            out_skipped_r <= 1'b0;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The running maximum never drops to zero.
  a_max_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    max_r != '0) else $error("running maximum is zero");

  // Sweep writes and write-back never collide on the single write port.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(sw_we_r && state_r == ST_WB)) else $error("store write collision");

  // Divider keeps the partial remainder below twice the shifted divisor.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> num_r < {dsh_r, 1'b0})
    else $error("quotient digit overflow");

  // After write-back the maximum covers the pixel count.
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |=> max_r >= $past(n_r))
    else $error("running maximum below pixel count");

endmodule

[design/julia_escape_iteration_store.sv]
// ----------------------------------------------------------------------------
// julia_escape_iteration_store
// Progressive Julia set escape-time renderer over a square pixel grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): cmd 0 advances pixel (x,y) by one
// iteration, cmd 1 restarts the whole grid. Each transfer yields exactly one
// result transfer on the output channel (out_valid/out_stall) in order.
// Items pass a two-entry queue to the iteration engine, which works on one
// item at a time. An iterate item passes from dequeue to result through
// a store read, the magnitude test and each complex product through a
// single shared 32x32 multiplier (no products when the pixel has already
// escaped), write-back and a restoring divide for the 8-bit green value;
// the next item is taken only after the result has been loaded. A skipped
// item is answered at dequeue. A restart answers at once, then the engine
// rewrites every pixel, one per cycle.
// After reset the engine builds its coordinate table and clears the grid;
// in_stall stays high for that time. A stalled output holds its result; the
// queue keeps taking items until it is full. Configuration is written
// through the APB port; the user must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module julia_escape_iteration_store #(
  parameter int GRID_SIDE  = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [6:0]                  in_x,
  input  logic [6:0]                  in_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_count,
  output logic [7:0]                  out_green,
  output logic                        out_skipped,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jesc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);

  jesc_pkg::cfg_t     cfg_r;
  jesc_pkg::reg_idx_t reg_sel;
  logic               push;
  logic [AW:0]        push_data;
  logic               pop;
  logic [AW:0]        pop_data;
  logic               q_full;
  logic               q_empty;
  logic               busy;

  assign pready  = 1'b1;
  assign reg_sel = jesc_pkg::reg_idx_t'(paddr[3:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_re      <= '0;
      cfg_r.c_im      <= '0;
      cfg_r.power     <= 3'd2;
      cfg_r.max_depth <= 16'd255;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        jesc_pkg::REG_C_RE:      cfg_r.c_re      <= pwdata;
        jesc_pkg::REG_C_IM:      cfg_r.c_im      <= pwdata;
        jesc_pkg::REG_POWER:     cfg_r.power     <= pwdata[2:0];
        jesc_pkg::REG_MAX_DEPTH: cfg_r.max_depth <= pwdata[15:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      jesc_pkg::REG_C_RE:      prdata = cfg_r.c_re;
      jesc_pkg::REG_C_IM:      prdata = cfg_r.c_im;
      jesc_pkg::REG_POWER:     prdata = {29'd0, cfg_r.power};
      jesc_pkg::REG_MAX_DEPTH: prdata = {16'd0, cfg_r.max_depth};
    endcase
  end

  jesc_front #(
    .GRID_SIDE (GRID_SIDE),
    .AW        (AW)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_x      (in_x),
    .in_y      (in_y),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  jesc_queue #(
    .W (AW + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  jesc_back #(
    .GRID_SIDE  (GRID_SIDE),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_count   (out_count),
    .out_green   (out_green),
    .out_skipped (out_skipped)
  );

endmodule

[verif/julia_escape_iteration_store_tb.sv]
// ----------------------------------------------------------------------------
// julia_escape_iteration_store_tb
// Self-checking bench for the Julia escape-time iteration store. A scoreboard
// keeps its own copy of the pixel grid and the running maximum, predicts each
// result from the accepted transfers and checks the results in order. The run
// goes through several constant, exponent and depth settings, a directed
// opening and random iterate and restart transfers under varying idling.
// ----------------------------------------------------------------------------
module julia_escape_iteration_store_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 128;
  localparam int CELLS = SIDE * SIDE;
  // Wait after the last result, long enough for a restart's grid clear to end.
  localparam int CLEAR_CYCLES = SIDE * SIDE + 200;

  typedef struct {
    logic [15:0] count;
    logic [7:0]  green;
    logic        skipped;
  } pixel_result_t;

  // Scoreboard: predicted grid state and the results still to come.
  class escape_scoreboard;
    int unsigned        iter_cnt[CELLS];
    logic signed [31:0] z_re[CELLS];
    logic signed [31:0] z_im[CELLS];
    int unsigned        peak;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [2:0]         pwr;
    logic [15:0]        depth;
    pixel_result_t      result_q[$];
    int                 errors;
    int                 checked;
    int                 skips;
    int                 restarts;

    function new();
      c_re = 0;
      c_im = 0;
      pwr = 3'd2;
      depth = 16'd255;
      errors = 0;
      checked = 0;
      skips = 0;
      restarts = 0;
      clear_grid();
    endfunction

    // Pixel index to Q6.26 coordinate in [-2.5, 2.5), truncated toward zero.
    function logic signed [31:0] coord(int p);
      longint num;
      num = longint'(p - SIDE / 2) * (longint'(5) << 25);
      return 32'(num / (SIDE / 2));
    endfunction

    function void clear_grid();
      for (int yi = 0; yi < SIDE; yi++) begin
        for (int xi = 0; xi < SIDE; xi++) begin
          iter_cnt[yi * SIDE + xi] = 0;
          z_re[yi * SIDE + xi] = coord(xi);
          z_im[yi * SIDE + xi] = coord(yi);
        end
      end
      peak = 1;
    endfunction

    function logic signed [31:0] sat(logic signed [65:0] v);
      if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -66'sh80000000) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Complex product with floor rounding of each part and saturation.
    function void cmul(input logic signed [31:0] ar, ai, br, bi,
                       output logic signed [31:0] rr, ri);
      logic signed [65:0] a_r, a_i, b_r, b_i;
      a_r = ar;
      a_i = ai;
      b_r = br;
      b_i = bi;
      rr = sat((a_r * b_r - a_i * b_i) >>> jesc_pkg::FRAC_BITS);
      ri = sat((a_r * b_i + a_i * b_r) >>> jesc_pkg::FRAC_BITS);
    endfunction

    function void write_reg(jesc_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        jesc_pkg::REG_C_RE:      c_re = val;
        jesc_pkg::REG_C_IM:      c_im = val;
        jesc_pkg::REG_POWER:     pwr = val[2:0];
        jesc_pkg::REG_MAX_DEPTH: depth = val[15:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted input transfer.
    function void note_input(logic cmd, logic [6:0] x, logic [6:0] y);
      pixel_result_t      r;
      int                 k;
      int                 p;
      logic signed [65:0] zr66, zi66, mag;
      logic signed [31:0] wr, wi, tr, ti;
      r.count = 0;
      r.green = 0;
      r.skipped = 0;
      if (cmd == jesc_pkg::CMD_RESTART) begin
        clear_grid();
        restarts++;
      end else if (peak >= depth) begin
        r.skipped = 1;
      end else begin
        k = int'(y) * SIDE + int'(x);
        zr66 = z_re[k];
        zi66 = z_im[k];
        mag = zr66 * zr66 + zi66 * zi66;
        if (mag < (66'sd4 <<< (2 * jesc_pkg::FRAC_BITS))) begin
          p = (pwr == 0) ? 1 : (pwr > 4) ? 4 : int'(pwr);
          wr = z_re[k];
          wi = z_im[k];
          for (int i = 1; i < p; i++) begin
            cmul(wr, wi, z_re[k], z_im[k], tr, ti);
            wr = tr;
            wi = ti;
          end
          z_re[k] = sat(66'(wr) + 66'(c_re));
          z_im[k] = sat(66'(wi) + 66'(c_im));
          if (iter_cnt[k] < 65535) iter_cnt[k]++;
        end
        if (iter_cnt[k] > peak) peak = iter_cnt[k];
        r.count = iter_cnt[k][15:0];
        r.green = 8'((longint'(iter_cnt[k]) * 255) / peak);
      end
      result_q.push_back(r);
    endfunction

    // Compare one accepted result transfer with the oldest prediction.
    function void check_result(logic [15:0] count, logic [7:0] green, logic skipped);
      pixel_result_t e;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result count=%0d green=%0d skipped=%0d",
                 $realtime, count, green, skipped);
        errors++;
        return;
      end
      e = result_q.pop_front();
      checked++;
      if (skipped) skips++;
      if (count !== e.count) begin
        $display("%0t: count mismatch expected %0d actual %0d", $realtime, e.count, count);
        errors++;
      end
      if (green !== e.green) begin
        $display("%0t: green mismatch expected %0d actual %0d", $realtime, e.green, green);
        errors++;
      end
      if (skipped !== e.skipped) begin
        $display("%0t: skipped mismatch expected %0d actual %0d",
                 $realtime, e.skipped, skipped);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_cmd = jesc_pkg::CMD_ITERATE;
  logic [6:0]                  in_x = '0;
  logic [6:0]                  in_y = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [15:0]                 out_count;
  logic [7:0]                  out_green;
  logic                        out_skipped;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [jesc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  escape_scoreboard grid_sb = new();
  int send_idle_pct = 27;
  int recv_idle_pct = 77;
  int sent = 0;
  logic [6:0] hot_x[8];
  logic [6:0] hot_y[8];

  julia_escape_iteration_store DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_x(in_x), .in_y(in_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_count(out_count), .out_green(out_green), .out_skipped(out_skipped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Random receiver stalls.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      grid_sb.check_result(out_count, out_green, out_skipped);
    end
  end

  // Overall time limit.
  initial begin
    #40ms;
    $display("Timeout with %0d results still pending", grid_sb.result_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Write one register through a setup and an access phase.
  task automatic cfg_write(jesc_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    grid_sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [31:0] cr, logic [31:0] ci, logic [2:0] pw, logic [15:0] dp);
    cfg_write(jesc_pkg::REG_C_RE, cr);
    cfg_write(jesc_pkg::REG_C_IM, ci);
    cfg_write(jesc_pkg::REG_POWER, {29'd0, pw});
    cfg_write(jesc_pkg::REG_MAX_DEPTH, {16'd0, dp});
  endtask

  // Set the idling mix from the share of items sent so far.
  task automatic pick_idling(int total);
    if (sent < total / 3) begin
      send_idle_pct = 27;
      recv_idle_pct = 77;
    end else if (sent < 2 * total / 3) begin
      send_idle_pct = 77;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Offer one item and wait for its transfer.
  task automatic send_item(logic cmd, logic [6:0] x, logic [6:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_x <= x;
    in_y <= y;
    do @(posedge clk); while (in_stall);
    grid_sb.note_input(cmd, x, y);
    sent++;
  endtask

  // Wait until all results are in and any grid clear has finished.
  task automatic drain();
    in_valid <= 1'b0;
    while (grid_sb.result_q.size() != 0) @(posedge clk);
    repeat (CLEAR_CYCLES) @(posedge clk);
  endtask

  // Random items: mostly a few hot pixels so counts grow deep, rare restarts.
  task automatic random_items(int n, int total);
    int h;
    for (int i = 0; i < 8; i++) begin
      hot_x[i] = 7'($urandom);
      hot_y[i] = 7'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      pick_idling(total);
      h = $urandom_range(7);
      if ($urandom_range(999) < 5) begin
        send_item(jesc_pkg::CMD_RESTART, 7'($urandom), 7'($urandom));
      end else if ($urandom_range(99) < 80) begin
        send_item(jesc_pkg::CMD_ITERATE, hot_x[h], hot_y[h]);
      end else begin
        send_item(jesc_pkg::CMD_ITERATE, 7'($urandom), 7'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    localparam int TOTAL = 1850;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall);

    // Directed opening: corners, center, restart and one pixel run deep.
    set_all(-32'sd53687091, 32'sd10468982, 3'd2, 16'd255);
    send_item(jesc_pkg::CMD_ITERATE, 7'd0, 7'd0);
    send_item(jesc_pkg::CMD_ITERATE, 7'd127, 7'd127);
    send_item(jesc_pkg::CMD_ITERATE, 7'd127, 7'd0);
    send_item(jesc_pkg::CMD_ITERATE, 7'd0, 7'd127);
    send_item(jesc_pkg::CMD_ITERATE, 7'd64, 7'd64);
    send_item(jesc_pkg::CMD_ITERATE, 7'd85, 7'd42);
    for (int i = 0; i < 12; i++) send_item(jesc_pkg::CMD_ITERATE, 7'd90, 7'd70);
    send_item(jesc_pkg::CMD_RESTART, 7'd127, 7'd127);
    send_item(jesc_pkg::CMD_ITERATE, 7'd90, 7'd70);
    send_item(jesc_pkg::CMD_ITERATE, 7'd64, 7'd64);
    drain();

    // Saturating constants with the highest exponent and the deepest limit.
    set_all(32'h7FFFFFFF, 32'h80000000, 3'd4, 16'hFFFF);
    random_items(300, TOTAL);
    // Linear map with a shallow depth so skipping sets in.
    set_all($urandom, $urandom, 3'd1, 16'd3);
    random_items(250, TOTAL);
    // Exponent zero acts as one; depth zero skips every iterate item.
    set_all(32'h80000000, 32'h7FFFFFFF, 3'd0, 16'd0);
    random_items(60, TOTAL);
    // Exponent seven acts as four.
    set_all(32'($urandom_range(67108863)) - 32'd33554432, 32'($urandom_range(67108863)),
            3'd7, 16'd40);
    random_items(300, TOTAL);
    // Cubic map, bounded constant, default depth.
    set_all(-32'sd26843545, 32'sd40265318, 3'd3, 16'd255);
    random_items(420, TOTAL);
    // Exponent six acts as four, with a classic bounded constant; depth one skips every iterate item.
    set_all(-32'sd52428800, 32'sd18119393, 3'd6, 16'd1);
    random_items(100, TOTAL);
    set_all(-32'sd47982, 32'sd42949672, 3'd2, 16'd1000);
    random_items(TOTAL - sent, TOTAL);

    $display("Covered %0d transfers in, %0d results checked (%0d skipped, %0d restarts).",
             sent, grid_sb.checked, grid_sb.skips, grid_sb.restarts);
    if (grid_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
